@@ hw/rtl/ax25fb_pkg.sv @@
package ax25fb_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CALL_W    = 48;
  localparam int unsigned SSID_W    = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_CALL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_SSID = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_CALL  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_SSID  = 8'd3;

  localparam logic [CALL_W-1:0] CALL_RESET = 48'h2020_2020_2020;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  CTRL_UI    = 8'h03;
  localparam logic [7:0]  PID_NONE   = 8'hF0;
  localparam logic [7:0]  SPACE_SHL  = 8'h40;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // Positions within the frame opening.
  localparam int unsigned OPEN_IDX_W = 5;
  localparam logic [OPEN_IDX_W-1:0] IDX_DEST0     = 5'd3;
  localparam logic [OPEN_IDX_W-1:0] IDX_DEST_SSID = 5'd9;
  localparam logic [OPEN_IDX_W-1:0] IDX_SRC0      = 5'd10;
  localparam logic [OPEN_IDX_W-1:0] IDX_SRC_SSID  = 5'd16;
  localparam logic [OPEN_IDX_W-1:0] IDX_CTRL      = 5'd17;
  localparam logic [OPEN_IDX_W-1:0] IDX_PID       = 5'd18;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef struct packed {
    logic [CALL_W-1:0] dest_call;
    logic [SSID_W-1:0] dest_ssid;
    logic [CALL_W-1:0] src_call;
    logic [SSID_W-1:0] src_ssid;
  } cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [7:0] info_byte;
    logic       frame_last;
    logic       open;
    logic       keep;
  } q_entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Callsign character at a position, shifted left; a zero character and all after it
  // go out as spaces.
  function automatic logic [7:0] addr_char(input logic [CALL_W-1:0] call,
                                           input logic [2:0] pos);
    logic       ended;
    logic [7:0] c;
    logic [7:0] res;
    ended = 1'b0;
    res   = SPACE_SHL;
    for (int k = 0; k < 6; k++) begin
      c = call[CALL_W-1-8*k -: 8];
      if (c == 8'h00) begin
        ended = 1'b1;
      end
      if (k == int'(pos)) begin
        res = ended ? SPACE_SHL : {c[6:0], 1'b0};
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] open_byte(input cfg_t cfg, input logic [OPEN_IDX_W-1:0] idx);
    logic [OPEN_IDX_W-1:0] d_off;
    logic [OPEN_IDX_W-1:0] s_off;
    logic [7:0]            res;
    d_off = idx - IDX_DEST0;
    s_off = idx - IDX_SRC0;
    if (idx < IDX_DEST0) begin
      res = FLAG_BYTE;
    end else if (idx < IDX_DEST_SSID) begin
      res = addr_char(cfg.dest_call, d_off[2:0]);
    end else if (idx == IDX_DEST_SSID) begin
      res = {3'b011, cfg.dest_ssid, 1'b0};
    end else if (idx < IDX_SRC_SSID) begin
      res = addr_char(cfg.src_call, s_off[2:0]);
    end else if (idx == IDX_SRC_SSID) begin
      res = {3'b011, cfg.src_ssid, 1'b1};
    end else if (idx == IDX_CTRL) begin
      res = CTRL_UI;
    end else begin
      res = PID_NONE;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/ax25fb_in_if.sv @@
interface ax25fb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] info_byte;
  logic       frame_last;

  modport source (output valid, output info_byte, output frame_last, input ready);
  modport sink   (input valid, input info_byte, input frame_last, output ready);
endinterface

@@ hw/rtl/ax25fb_out_if.sv @@
interface ax25fb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, output out_byte, output run_last, output frame_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_done,
                  output ready);
endinterface

@@ hw/rtl/ax25fb_cfg_if.sv @@
interface ax25fb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ax25fb_pkg::CFG_IDX_W-1:0]  index;
  logic [ax25fb_pkg::CALL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/ax25_ui_frame_builder.sv @@
// The first byte an item causes passes through the queue and is then registered in the
// output stage.
// One output byte per cycle while the output is ready and the queue holds an entry; an
// item causes 1 byte for a plain info byte, 20 for a frame's first byte, up to 23 in all.
// Input stalls only when the four-entry queue ahead of the byte sequencer is full.
// Reset (rst, synchronous, active high) clears the queue, closes any open frame,
// sets the CRC to 0xFFFF and loads both callsigns with six spaces and SSIDs with zero.
module ax25_ui_frame_builder #(
  parameter int unsigned MAX_INFO = 256
) (
  input  logic          clk,
  input  logic          rst,
  ax25fb_in_if.sink     in_ch,
  ax25fb_out_if.source  out_ch,
  ax25fb_cfg_if.sink    cfg_ch
);

  // The configuration registers are always ready to be written. They are meant to be
  // changed only between frames, so the sequencer reads them directly while it sends
  // the address fields of a frame opening.
  ax25fb_pkg::cfg_t     cfg;

  // The front classifies each item (does it open a frame, is it kept or dropped for
  // overflow) and the back turns each queue entry into its run of frame bytes.
  logic                 push;
  ax25fb_pkg::q_entry_t push_data;
  logic                 q_full;
  logic                 pop;
  ax25fb_pkg::q_entry_t head;
  logic                 q_empty;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_call <= ax25fb_pkg::CALL_RESET;
      cfg.dest_ssid <= '0;
      cfg.src_call  <= ax25fb_pkg::CALL_RESET;
      cfg.src_ssid  <= '0;
    end else if (cfg_ch.valid) begin
      // Writes to an index beyond the register list are ignored.
      case (cfg_ch.index)
        ax25fb_pkg::CFG_DEST_CALL: cfg.dest_call <= cfg_ch.data;
        ax25fb_pkg::CFG_DEST_SSID: cfg.dest_ssid <= cfg_ch.data[ax25fb_pkg::SSID_W-1:0];
        ax25fb_pkg::CFG_SRC_CALL:  cfg.src_call  <= cfg_ch.data;
        ax25fb_pkg::CFG_SRC_SSID:  cfg.src_ssid  <= cfg_ch.data[ax25fb_pkg::SSID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ax25fb_front #(
    .MAX_INFO (MAX_INFO)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ax25fb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // The back holds the running CRC and a registered output stage, so a waiting
  // output item holds up the front only once the queue has filled.
  ax25fb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ hw/rtl/ax25fb_front.sv @@
module ax25fb_front #(
  parameter int unsigned MAX_INFO = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  ax25fb_in_if.sink            in_ch,
  input  logic                 q_full,
  output logic                 push,
  output ax25fb_pkg::q_entry_t push_data
);

  localparam int unsigned CNT_W = $clog2(MAX_INFO + 1);

  logic             in_frame;
  logic [CNT_W-1:0] info_count;
  logic             accept;
  logic             keep;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign keep        = info_count < CNT_W'(MAX_INFO);

  // An overflowing byte that does not close the frame has nothing to send.
  assign push                 = accept && (keep || in_ch.frame_last);
  assign push_data.info_byte  = in_ch.info_byte;
  assign push_data.frame_last = in_ch.frame_last;
  assign push_data.open       = !in_frame;
  assign push_data.keep       = keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      info_count <= '0;
    end else if (accept) begin
      if (in_ch.frame_last) begin
        in_frame   <= 1'b0;
        info_count <= '0;
      end else begin
        in_frame <= 1'b1;
        if (keep) begin
          info_count <= info_count + 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/ax25fb_queue.sv @@
module ax25fb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ax25fb_pkg::q_entry_t push_data,
  output logic                 full,
  input  logic                 pop,
  output ax25fb_pkg::q_entry_t head,
  output logic                 empty
);

  ax25fb_pkg::q_entry_t               mem [ax25fb_pkg::QUEUE_DEPTH];
  logic [ax25fb_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ax25fb_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ax25fb_pkg::QPTR_W:0]        count;

  assign full  = count == (ax25fb_pkg::QPTR_W+1)'(ax25fb_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/ax25fb_back.sv @@
module ax25fb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ax25fb_pkg::cfg_t     cfg,
  input  ax25fb_pkg::q_entry_t head,
  input  logic                 empty,
  output logic                 pop,
  ax25fb_out_if.source         out_ch
);

  typedef enum logic [2:0] {
    P_OPEN,
    P_INFO,
    P_FCS_LO,
    P_FCS_HI,
    P_CLOSE
  } phase_t;

  phase_t                                phase;
  phase_t                                cur_phase;
  phase_t                                phase_next;
  logic                                  busy;
  logic [ax25fb_pkg::OPEN_IDX_W-1:0]     idx;
  logic [ax25fb_pkg::OPEN_IDX_W-1:0]     cur_idx;
  logic [15:0]                           fcs;
  logic [7:0]                            cur_byte;
  logic                                  covered;
  logic                                  done;
  logic                                  advance;
  logic                                  emit;

  logic                                  ovalid;
  logic [7:0]                            obyte;
  logic                                  orun_last;
  logic                                  oframe_done;

  assign out_ch.valid      = ovalid;
  assign out_ch.out_byte   = obyte;
  assign out_ch.run_last   = orun_last;
  assign out_ch.frame_done = oframe_done;

  assign advance = !ovalid || out_ch.ready;
  assign emit    = advance && !empty;
  assign pop     = emit && done;

  always_comb begin
    if (busy) begin
      cur_phase = phase;
      cur_idx   = idx;
    end else begin
      cur_idx   = '0;
      if (head.open) begin
        cur_phase = P_OPEN;
      end else if (head.keep) begin
        cur_phase = P_INFO;
      end else begin
        cur_phase = P_FCS_LO;
      end
    end

    done       = 1'b0;
    phase_next = cur_phase;
    covered    = 1'b0;
    case (cur_phase)
      P_OPEN: begin
        cur_byte = ax25fb_pkg::open_byte(cfg, cur_idx);
        covered  = cur_idx >= ax25fb_pkg::IDX_DEST0;
        if (cur_idx == ax25fb_pkg::IDX_PID) begin
          phase_next = head.keep ? P_INFO : P_FCS_LO;
        end
      end
      P_INFO: begin
        cur_byte = head.info_byte;
        covered  = 1'b1;
        if (head.frame_last) begin
          phase_next = P_FCS_LO;
        end else begin
          done = 1'b1;
        end
      end
      P_FCS_LO: begin
        cur_byte   = ~fcs[7:0];
        phase_next = P_FCS_HI;
      end
      P_FCS_HI: begin
        cur_byte   = ~fcs[15:8];
        phase_next = P_CLOSE;
      end
      P_CLOSE: begin
        cur_byte = ax25fb_pkg::FLAG_BYTE;
        done     = 1'b1;
      end
      default: begin
        cur_byte = ax25fb_pkg::FLAG_BYTE;
        done     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= P_OPEN;
      busy        <= 1'b0;
      idx         <= '0;
      fcs         <= ax25fb_pkg::CRC_INIT;
      ovalid      <= 1'b0;
      obyte       <= '0;
      orun_last   <= 1'b0;
      oframe_done <= 1'b0;
    end else if (emit) begin
      ovalid      <= 1'b1;
      obyte       <= cur_byte;
      orun_last   <= done;
      oframe_done <= cur_phase == P_CLOSE;
      busy        <= !done;
      phase       <= phase_next;
      idx         <= (cur_phase == P_OPEN) ? cur_idx + 1'b1 : '0;
      if (cur_phase == P_CLOSE) begin
        fcs <= ax25fb_pkg::CRC_INIT;
      end else if (covered) begin
        fcs <= ax25fb_pkg::crc_byte(fcs, cur_byte);
      end
    end else if (advance) begin
      ovalid <= 1'b0;
    end
  end

endmodule

@@ tb/sv/tb_ax25_ui_frame_builder.sv @@
module tb_ax25_ui_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  // The frame builder is run with the standard information field limit.
  localparam int MAX_INFO_LEN = 256;

  // Cycles to let pass once the last expected byte has come out, so that any
  // stray output from the block shows before the next step.
  localparam int SETTLE_CYCLES = 16;

  // Generous bound: every item at its worst byte count, every byte behind the
  // longest output stall, taken several times over.
  localparam int CYCLE_LIMIT = 3_000_000;

  // One byte of the outgoing frame, as the output channel carries it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst;

  ax25fb_in_if  in_if();
  ax25fb_out_if out_if();
  ax25fb_cfg_if cfg_if();

  ax25_ui_frame_builder #(
    .MAX_INFO(MAX_INFO_LEN)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // 12 ns period.
  always #6 clk = ~clk;

  // Predictor state: the register settings and the framing state of the block,
  // kept up to date from the handshakes seen at each rising edge.
  logic [ax25fb_pkg::CALL_W-1:0] pred_dest_call;
  logic [ax25fb_pkg::SSID_W-1:0] pred_dest_ssid;
  logic [ax25fb_pkg::CALL_W-1:0] pred_src_call;
  logic [ax25fb_pkg::SSID_W-1:0] pred_src_ssid;
  logic                          pred_frame_open;
  logic [15:0]                   pred_crc;
  int                            pred_info_seen;
  int                            pred_run_len;

  // Frame bytes predicted but not yet seen at the output, oldest first.
  frame_byte_t pending_frame_bytes[$];

  int mismatch_count = 0;

  // When set, neither side idles, so the block runs at full rate.
  bit steady = 1'b0;

  // One step of the reflected CRC-16, taking the byte least significant bit first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        lsb;
    int          k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      lsb = c[0];
      c   = {1'b0, c[15:1]};
      if (lsb) begin
        c = c ^ ax25fb_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  // Queues one predicted byte; bytes between the opening flags and the FCS are
  // folded into the running CRC.
  function automatic void emit_byte(input logic [7:0] b, input bit covered, input bit done);
    frame_byte_t fb;
    fb.out_byte   = b;
    fb.run_last   = 1'b0;
    fb.frame_done = done;
    pending_frame_bytes.push_back(fb);
    if (covered) begin
      pred_crc = crc_step(pred_crc, b);
    end
    pred_run_len++;
  endfunction

  // Six callsign characters followed by the SSID byte. Once a zero character
  // turns up, it and every character after it go out as spaces. Bit 7 of each
  // character falls off in the shift.
  function automatic void emit_address(input logic [ax25fb_pkg::CALL_W-1:0] call,
                                       input logic [ax25fb_pkg::SSID_W-1:0] ssid,
                                       input bit is_source);
    logic [7:0] ch;
    logic [7:0] ssid_byte;
    bit         ended;
    int         k;
    ended = 1'b0;
    for (k = 0; k < 6; k++) begin
      ch = call[ax25fb_pkg::CALL_W-1-8*k -: 8];
      if (ch == 8'h00) begin
        ended = 1'b1;
      end
      if (ended) begin
        ch = 8'h20;
      end
      emit_byte({ch[6:0], 1'b0}, 1'b1, 1'b0);
    end
    ssid_byte = (8'h30 + {4'h0, ssid}) << 1;
    if (is_source) begin
      ssid_byte[0] = 1'b1;
    end
    emit_byte(ssid_byte, 1'b1, 1'b0);
  endfunction

  // Works out every frame byte that one accepted info item causes.
  function automatic void predict_frame_bytes(input logic [7:0] info, input logic last);
    logic [15:0] fcs;
    frame_byte_t tail;
    pred_run_len = 0;
    if (!pred_frame_open) begin
      pred_crc       = ax25fb_pkg::CRC_INIT;
      pred_info_seen = 0;
      repeat (3) emit_byte(ax25fb_pkg::FLAG_BYTE, 1'b0, 1'b0);
      emit_address(pred_dest_call, pred_dest_ssid, 1'b0);
      emit_address(pred_src_call, pred_src_ssid, 1'b1);
      emit_byte(ax25fb_pkg::CTRL_UI, 1'b1, 1'b0);
      emit_byte(ax25fb_pkg::PID_NONE, 1'b1, 1'b0);
      pred_frame_open = 1'b1;
    end
    // Past the limit the byte is neither sent nor covered by the FCS.
    if (pred_info_seen < MAX_INFO_LEN) begin
      emit_byte(info, 1'b1, 1'b0);
      pred_info_seen++;
    end
    // The frame closes even when its last byte was dropped.
    if (last) begin
      fcs = ~pred_crc;
      emit_byte(fcs[7:0], 1'b0, 1'b0);
      emit_byte(fcs[15:8], 1'b0, 1'b0);
      emit_byte(ax25fb_pkg::FLAG_BYTE, 1'b0, 1'b1);
      pred_frame_open = 1'b0;
      pred_crc        = ax25fb_pkg::CRC_INIT;
      pred_info_seen  = 0;
    end
    if (pred_run_len > 0) begin
      tail          = pending_frame_bytes.pop_back();
      tail.run_last = 1'b1;
      pending_frame_bytes.push_back(tail);
    end
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %02h, actual %02h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Most gaps are short, a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 50);
  endfunction

  // A callsign for random settings: printable calls padded with spaces, raw
  // random bits, or random bits with a zero character somewhere in them.
  function automatic logic [ax25fb_pkg::CALL_W-1:0] random_callsign();
    logic [ax25fb_pkg::CALL_W-1:0] call;
    logic [7:0]                    r;
    int                            n;
    int                            k;
    call = {16'($urandom), 32'($urandom)};
    case ($urandom_range(0, 3))
      0: begin
      end
      1: begin
        n = $urandom_range(0, 5);
        call[ax25fb_pkg::CALL_W-1-8*n -: 8] = 8'h00;
      end
      default: begin
        n = $urandom_range(1, 6);
        for (k = 0; k < 6; k++) begin
          r = 8'($urandom_range(0, 35));
          if (k >= n) begin
            call[ax25fb_pkg::CALL_W-1-8*k -: 8] = 8'h20;
          end else if (r < 8'd26) begin
            call[ax25fb_pkg::CALL_W-1-8*k -: 8] = 8'h41 + r;
          end else begin
            call[ax25fb_pkg::CALL_W-1-8*k -: 8] = 8'h30 + r - 8'd26;
          end
        end
      end
    endcase
    return call;
  endfunction

  // Sends one info item and waits for it to be taken, then idles for a while.
  // With no gap, valid simply stays high for the next item.
  task automatic send_info(input logic [7:0] info, input logic last);
    int gap;
    @(negedge clk);
    in_if.valid      = 1'b1;
    in_if.info_byte  = info;
    in_if.frame_last = last;
    do @(posedge clk); while (!in_if.ready);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic cfg_write(input logic [ax25fb_pkg::CFG_IDX_W-1:0] index,
                           input logic [ax25fb_pkg::CALL_W-1:0] data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = index;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Holds the sender off until every predicted byte has come out, then lets a
  // few more cycles pass so that any stray output shows.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Frames under the reset settings: six spaces and SSID zero on both sides.
  task automatic test_reset_defaults();
    send_info(8'h00, 1'b1);
    send_info(8'hFF, 1'b1);
    send_info(8'h55, 1'b0);
    send_info(8'hAA, 1'b1);
  endtask

  // Address extremes: an all-zero callsign goes out as spaces, an all-ones one
  // loses bit 7 of every character, and a zero in the middle blanks the rest.
  // Indexes past the last register must leave the settings alone.
  task automatic test_address_extremes();
    wait_idle();
    cfg_write(ax25fb_pkg::CFG_DEST_CALL, 48'h0000_0000_0000);
    cfg_write(ax25fb_pkg::CFG_DEST_SSID, 48'hFFFF_FFFF_FFFF);
    cfg_write(ax25fb_pkg::CFG_SRC_CALL,  48'hFFFF_FFFF_FFFF);
    cfg_write(ax25fb_pkg::CFG_SRC_SSID,  48'hFFFF_FFFF_FFF0);
    send_info(8'h01, 1'b1);
    wait_idle();
    cfg_write(ax25fb_pkg::CFG_DEST_CALL, 48'h4E30_4300_4C4C);
    cfg_write(ax25fb_pkg::CFG_DEST_SSID, 48'h0000_0000_0000);
    cfg_write(ax25fb_pkg::CFG_SRC_CALL,  48'hC1C2_B1C3_C4C5);
    cfg_write(ax25fb_pkg::CFG_SRC_SSID,  48'h0000_0000_000F);
    send_info(8'h80, 1'b0);
    send_info(8'h7F, 1'b1);
    wait_idle();
    cfg_write(ax25fb_pkg::CFG_SRC_SSID + 8'd1, {16'($urandom), 32'($urandom)});
    cfg_write(8'hFF, {16'($urandom), 32'($urandom)});
    send_info(8'h3C, 1'b1);
  endtask

  // The sender stops mid-frame until the output has caught up; settings
  // written then must only show in the next frame's opening.
  task automatic test_mid_frame_pause();
    send_info(8'h12, 1'b0);
    send_info(8'h34, 1'b0);
    send_info(8'h56, 1'b0);
    wait_idle();
    cfg_write(ax25fb_pkg::CFG_DEST_CALL, 48'h5445_5354_3031);
    cfg_write(ax25fb_pkg::CFG_SRC_SSID,  48'h0000_0000_0007);
    send_info(8'h78, 1'b0);
    send_info(8'h9A, 1'b1);
    send_info(8'hBC, 1'b1);
  endtask

  // Short frames back to back with neither side idling.
  task automatic test_back_to_back();
    int i;
    steady = 1'b1;
    for (i = 0; i < 8; i++) begin
      send_info(8'($urandom), (i % 3) != 0);
    end
    steady = 1'b0;
  endtask

  // A frame that runs past the information field: the first bytes fill it, the
  // next one is dropped without output, and the one marked last is dropped too
  // yet still closes the frame.
  task automatic test_info_overflow();
    int i;
    for (i = 1; i <= MAX_INFO_LEN + 2; i++) begin
      send_info(8'($urandom), i == MAX_INFO_LEN + 2);
    end
  endtask

  // Random well-formed frames in several phases, each under its own settings.
  // The first and last phases take the lowest and highest register values.
  task automatic test_random_frames();
    logic [ax25fb_pkg::CFG_IDX_W-1:0] cfg_order[4];
    logic [ax25fb_pkg::CFG_IDX_W-1:0] idx;
    logic [ax25fb_pkg::CALL_W-1:0]    data;
    int                               phase;
    int                               sent;
    int                               len;
    int                               start;
    int                               i;
    int                               r;
    cfg_order = '{ax25fb_pkg::CFG_DEST_CALL, ax25fb_pkg::CFG_DEST_SSID,
                  ax25fb_pkg::CFG_SRC_CALL, ax25fb_pkg::CFG_SRC_SSID};
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      start  = $urandom_range(0, 3);
      for (i = 0; i < 4; i++) begin
        idx  = cfg_order[(start + i) % 4];
        data = {16'($urandom), 32'($urandom)};
        if (phase == 0) begin
          data = '0;
        end else if (phase == 3) begin
          data = '1;
        end else if (idx == ax25fb_pkg::CFG_DEST_CALL || idx == ax25fb_pkg::CFG_SRC_CALL) begin
          data = random_callsign();
        end
        cfg_write(idx, data);
      end
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(8'($urandom_range(int'(ax25fb_pkg::CFG_SRC_SSID) + 1, 255)),
                  {16'($urandom), 32'($urandom)});
      end
      sent = 0;
      while (sent < 4) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          len = $urandom_range(1, 6);
        end else begin
          len = $urandom_range(7, 16);
        end
        for (i = 1; i <= len; i++) begin
          send_info(8'($urandom), i == len);
          sent++;
          // Now and then the sender waits mid-frame and a new SSID goes in.
          if (i == 2 && len > 3 && $urandom_range(0, 9) == 0) begin
            wait_idle();
            cfg_write(ax25fb_pkg::CFG_DEST_SSID, {16'($urandom), 32'($urandom)});
          end
        end
      end
    end
    steady = 1'b0;
  endtask

  // Output backpressure: runs of ready, broken by stalls of random length.
  int ready_run  = 0;
  int ready_hold = 0;

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_if.ready = 1'b0;
      ready_hold--;
    end else begin
      out_if.ready = 1'b1;
      if (ready_run > 0) begin
        ready_run--;
      end else begin
        ready_run  = $urandom_range(0, 30);
        ready_hold = pick_gap();
      end
    end
  end

  // Everything is sampled at the rising edge: settings and info items update
  // the predictor, and each frame byte taken is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          ax25fb_pkg::CFG_DEST_CALL: pred_dest_call = cfg_if.data;
          ax25fb_pkg::CFG_DEST_SSID: pred_dest_ssid = cfg_if.data[ax25fb_pkg::SSID_W-1:0];
          ax25fb_pkg::CFG_SRC_CALL:  pred_src_call  = cfg_if.data;
          ax25fb_pkg::CFG_SRC_SSID:  pred_src_ssid  = cfg_if.data[ax25fb_pkg::SSID_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        predict_frame_bytes(in_if.info_byte, in_if.frame_last);
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_frame_bytes.size() == 0) begin
          $display("%0t ns: frame byte with none expected, actual %02h run_last %0b done %0b",
                   $time, out_if.out_byte, out_if.run_last, out_if.frame_done);
          mismatch_count++;
        end else begin
          want = pending_frame_bytes.pop_front();
          check_field("out_byte", want.out_byte, out_if.out_byte);
          check_field("run_last", {7'h00, want.run_last}, {7'h00, out_if.run_last});
          check_field("frame_done", {7'h00, want.frame_done}, {7'h00, out_if.frame_done});
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_ax25_ui_frame_builder: errors");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    in_if.valid      = 1'b0;
    in_if.info_byte  = 8'h00;
    in_if.frame_last = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = ax25fb_pkg::CFG_DEST_CALL;
    cfg_if.data      = '0;

    pred_dest_call  = ax25fb_pkg::CALL_RESET;
    pred_dest_ssid  = '0;
    pred_src_call   = ax25fb_pkg::CALL_RESET;
    pred_src_ssid   = '0;
    pred_frame_open = 1'b0;
    pred_crc        = ax25fb_pkg::CRC_INIT;
    pred_info_seen  = 0;
    pred_run_len    = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_address_extremes();
    test_mid_frame_pause();
    test_back_to_back();
    test_info_overflow();
    test_random_frames();

    // Wait for the last frame bytes and give the block time to show any stray
    // output before the verdict.
    wait_idle();
    if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
      $display("tb_ax25_ui_frame_builder: clean");
    end else begin
      $display("tb_ax25_ui_frame_builder: errors");
    end
    $finish;
  end

endmodule
